@@ src/cbms_pkg.sv @@
package cbms_pkg;

	// Frame size limits.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// Field widths.
	localparam int SIZE_W  = 11;
	localparam int LABEL_W = 8;
	localparam int POS_W   = 10;
	localparam int AREA_W  = 21;
	localparam int SUM_W   = 30;
	localparam int SQ_W    = 40;
	localparam int PROD_W  = 2 * POS_W;
	localparam int IDX_W   = 3;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_WIDTH    = 3'd0,
		REG_IMAGE_HEIGHT   = 3'd1,
		REG_TARGET_LABEL   = 3'd2,
		REG_WINDOW_X_START = 3'd3,
		REG_WINDOW_X_END   = 3'd4,
		REG_WINDOW_Y_START = 3'd5,
		REG_WINDOW_Y_END   = 3'd6
	} cfg_reg_t;

	// Effective settings; sizes saturated, window ends clamped to the frame.
	typedef struct packed {
		logic [POS_W-1:0]   x_last;
		logic [POS_W-1:0]   y_last;
		logic [POS_W-1:0]   x_start;
		logic [POS_W-1:0]   x_end;
		logic [POS_W-1:0]   y_start;
		logic [POS_W-1:0]   y_end;
		logic [LABEL_W-1:0] target;
	} cfg_t;

	// One classified pixel handed to the accumulators.
	typedef struct packed {
		logic              hit;
		logic              frame_end;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [PROD_W-1:0] xx;
		logic [PROD_W-1:0] yy;
		logic [PROD_W-1:0] xy;
	} sample_t;

endpackage

@@ src/cbms_pixel_if.sv @@
interface cbms_pixel_if;
	logic                        valid;
	logic                        ready;
	logic [cbms_pkg::LABEL_W-1:0] pixel_label;

	modport source (output valid, output pixel_label, input ready);
	modport sink (input valid, input pixel_label, output ready);
endinterface

@@ src/cbms_moment_if.sv @@
interface cbms_moment_if;
	logic                        valid;
	logic                        ready;
	logic [cbms_pkg::AREA_W-1:0] area;
	logic [cbms_pkg::POS_W-1:0]  min_x;
	logic [cbms_pkg::POS_W-1:0]  max_x;
	logic [cbms_pkg::POS_W-1:0]  min_y;
	logic [cbms_pkg::POS_W-1:0]  max_y;
	logic [cbms_pkg::SUM_W-1:0]  sum_x;
	logic [cbms_pkg::SUM_W-1:0]  sum_y;
	logic [cbms_pkg::SQ_W-1:0]   sum_xx;
	logic [cbms_pkg::SQ_W-1:0]   sum_yy;
	logic [cbms_pkg::SQ_W-1:0]   sum_xy;

	modport source (output valid, output area, output min_x, output max_x, output min_y,
		output max_y, output sum_x, output sum_y, output sum_xx, output sum_yy,
		output sum_xy, input ready);
	modport sink (input valid, input area, input min_x, input max_x, input min_y,
		input max_y, input sum_x, input sum_y, input sum_xx, input sum_yy,
		input sum_xy, output ready);
endinterface

@@ src/cbms_cfg_regs.sv @@
module cbms_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [cbms_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [cbms_pkg::SIZE_W-1:0]   cfg_wdata,
	output cbms_pkg::cfg_t                cfg
);

	logic [cbms_pkg::SIZE_W-1:0]  image_width_q;
	logic [cbms_pkg::SIZE_W-1:0]  image_height_q;
	logic [cbms_pkg::LABEL_W-1:0] target_label_q;
	logic [cbms_pkg::POS_W-1:0]   window_x_start_q;
	logic [cbms_pkg::POS_W-1:0]   window_x_end_q;
	logic [cbms_pkg::POS_W-1:0]   window_y_start_q;
	logic [cbms_pkg::POS_W-1:0]   window_y_end_q;
	logic [cbms_pkg::POS_W-1:0]   x_last;
	logic [cbms_pkg::POS_W-1:0]   y_last;

	// Register file; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q    <= cbms_pkg::SIZE_W'(cbms_pkg::MAX_WIDTH);
			image_height_q   <= cbms_pkg::SIZE_W'(cbms_pkg::MAX_HEIGHT);
			target_label_q   <= cbms_pkg::LABEL_W'(1);
			window_x_start_q <= '0;
			window_x_end_q   <= '1;
			window_y_start_q <= '0;
			window_y_end_q   <= '1;
		end else if (cfg_wen) begin
			case (cbms_pkg::cfg_reg_t'(cfg_idx))
				cbms_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_wdata;
				end
				cbms_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_wdata;
				end
				cbms_pkg::REG_TARGET_LABEL: begin
					target_label_q <= cfg_wdata[cbms_pkg::LABEL_W-1:0];
				end
				cbms_pkg::REG_WINDOW_X_START: begin
					window_x_start_q <= cfg_wdata[cbms_pkg::POS_W-1:0];
				end
				cbms_pkg::REG_WINDOW_X_END: begin
					window_x_end_q <= cfg_wdata[cbms_pkg::POS_W-1:0];
				end
				cbms_pkg::REG_WINDOW_Y_START: begin
					window_y_start_q <= cfg_wdata[cbms_pkg::POS_W-1:0];
				end
				cbms_pkg::REG_WINDOW_Y_END: begin
					window_y_end_q <= cfg_wdata[cbms_pkg::POS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Last column and row: the size saturated into one up to the maximum, minus one.
	always_comb begin
		if (image_width_q == '0) begin
			x_last = '0;
		end else if (image_width_q > cbms_pkg::SIZE_W'(cbms_pkg::MAX_WIDTH)) begin
			x_last = cbms_pkg::POS_W'(cbms_pkg::MAX_WIDTH - 1);
		end else begin
			x_last = cbms_pkg::POS_W'(image_width_q - 1'b1);
		end

		if (image_height_q == '0) begin
			y_last = '0;
		end else if (image_height_q > cbms_pkg::SIZE_W'(cbms_pkg::MAX_HEIGHT)) begin
			y_last = cbms_pkg::POS_W'(cbms_pkg::MAX_HEIGHT - 1);
		end else begin
			y_last = cbms_pkg::POS_W'(image_height_q - 1'b1);
		end
	end

	// The window end never reaches past the frame.
	always_comb begin
		cfg.x_last  = x_last;
		cfg.y_last  = y_last;
		cfg.x_start = window_x_start_q;
		cfg.x_end   = (window_x_end_q < x_last) ? window_x_end_q : x_last;
		cfg.y_start = window_y_start_q;
		cfg.y_end   = (window_y_end_q < y_last) ? window_y_end_q : y_last;
		cfg.target  = target_label_q;
	end

endmodule

@@ src/cbms_scan.sv @@
module cbms_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cbms_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	input  logic [cbms_pkg::LABEL_W-1:0]  in_label,
	output logic                          in_ready,
	output logic                          smp_valid,
	output cbms_pkg::sample_t             smp,
	input  logic                          smp_ready
);

	logic [cbms_pkg::POS_W-1:0]   col_q;
	logic [cbms_pkg::POS_W-1:0]   row_q;
	logic                         row_end;
	logic                         frame_end;
	logic                         in_take;
	logic                         s1_valid_q;
	logic [cbms_pkg::LABEL_W-1:0] label_s1;
	logic [cbms_pkg::POS_W-1:0]   x_s1;
	logic [cbms_pkg::POS_W-1:0]   y_s1;
	logic                         frame_end_s1;
	logic                         s1_adv;
	logic                         s2_valid_q;
	cbms_pkg::sample_t            smp_s2;
	logic                         s2_adv;
	logic                         hit;

	// Stage flow: a stage moves on when it is empty or the next one takes it.
	assign s2_adv   = !s2_valid_q || smp_ready;
	assign s1_adv   = !s1_valid_q || s2_adv;
	assign in_ready = s1_adv;
	assign in_take  = in_valid && s1_adv;

	// Raster position; a counter at or past the last column closes the row.
	assign row_end   = col_q >= cfg.x_last;
	assign frame_end = row_end && (row_q >= cfg.y_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_take) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Stage one valid and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			label_s1     <= in_label;
			x_s1         <= col_q;
			y_s1         <= row_q;
			frame_end_s1 <= frame_end;
		end
	end

	// Label and window test.
	assign hit = (label_s1 == cfg.target) &&
		(x_s1 >= cfg.x_start) && (x_s1 <= cfg.x_end) &&
		(y_s1 >= cfg.y_start) && (y_s1 <= cfg.y_end);

	// Stage two valid and payload, with the three products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_adv) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && s1_valid_q) begin
			smp_s2.hit       <= hit;
			smp_s2.frame_end <= frame_end_s1;
			smp_s2.x         <= x_s1;
			smp_s2.y         <= y_s1;
			smp_s2.xx        <= cbms_pkg::PROD_W'(x_s1) * cbms_pkg::PROD_W'(x_s1);
			smp_s2.yy        <= cbms_pkg::PROD_W'(y_s1) * cbms_pkg::PROD_W'(y_s1);
			smp_s2.xy        <= cbms_pkg::PROD_W'(x_s1) * cbms_pkg::PROD_W'(y_s1);
		end
	end

	assign smp_valid = s2_valid_q;
	assign smp       = smp_s2;

endmodule

@@ src/cbms_accum.sv @@
module cbms_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  cbms_pkg::cfg_t    cfg,
	input  logic              smp_valid,
	input  cbms_pkg::sample_t smp,
	output logic              smp_ready,
	cbms_moment_if.source     moments
);

	logic [cbms_pkg::AREA_W-1:0] area_q;
	logic [cbms_pkg::POS_W-1:0]  min_x_q;
	logic [cbms_pkg::POS_W-1:0]  max_x_q;
	logic [cbms_pkg::POS_W-1:0]  min_y_q;
	logic [cbms_pkg::POS_W-1:0]  max_y_q;
	logic [cbms_pkg::SUM_W-1:0]  sum_x_q;
	logic [cbms_pkg::SUM_W-1:0]  sum_y_q;
	logic [cbms_pkg::SQ_W-1:0]   sum_xx_q;
	logic [cbms_pkg::SQ_W-1:0]   sum_yy_q;
	logic [cbms_pkg::SQ_W-1:0]   sum_xy_q;

	logic [cbms_pkg::AREA_W-1:0] area_n;
	logic [cbms_pkg::POS_W-1:0]  min_x_n;
	logic [cbms_pkg::POS_W-1:0]  max_x_n;
	logic [cbms_pkg::POS_W-1:0]  min_y_n;
	logic [cbms_pkg::POS_W-1:0]  max_y_n;
	logic [cbms_pkg::SUM_W-1:0]  sum_x_n;
	logic [cbms_pkg::SUM_W-1:0]  sum_y_n;
	logic [cbms_pkg::SQ_W-1:0]   sum_xx_n;
	logic [cbms_pkg::SQ_W-1:0]   sum_yy_n;
	logic [cbms_pkg::SQ_W-1:0]   sum_xy_n;

	logic out_valid_q;
	logic take;

	// A frame-closing pixel waits until the result register is free.
	assign smp_ready = !smp.frame_end || !out_valid_q || moments.ready;
	assign take      = smp_valid && smp_ready;

	// Totals with this pixel folded in.
	always_comb begin
		area_n   = area_q;
		min_x_n  = min_x_q;
		max_x_n  = max_x_q;
		min_y_n  = min_y_q;
		max_y_n  = max_y_q;
		sum_x_n  = sum_x_q;
		sum_y_n  = sum_y_q;
		sum_xx_n = sum_xx_q;
		sum_yy_n = sum_yy_q;
		sum_xy_n = sum_xy_q;
		if (smp.hit) begin
			area_n   = area_q + 1'b1;
			min_x_n  = (smp.x < min_x_q) ? smp.x : min_x_q;
			max_x_n  = (smp.x > max_x_q) ? smp.x : max_x_q;
			min_y_n  = (smp.y < min_y_q) ? smp.y : min_y_q;
			max_y_n  = (smp.y > max_y_q) ? smp.y : max_y_q;
			sum_x_n  = sum_x_q + cbms_pkg::SUM_W'(smp.x);
			sum_y_n  = sum_y_q + cbms_pkg::SUM_W'(smp.y);
			sum_xx_n = sum_xx_q + cbms_pkg::SQ_W'(smp.xx);
			sum_yy_n = sum_yy_q + cbms_pkg::SQ_W'(smp.yy);
			sum_xy_n = sum_xy_q + cbms_pkg::SQ_W'(smp.xy);
		end
	end

	// Accumulators; they restart after the frame's last pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q   <= '0;
			min_x_q  <= cbms_pkg::POS_W'(cbms_pkg::MAX_WIDTH - 1);
			max_x_q  <= '0;
			min_y_q  <= cbms_pkg::POS_W'(cbms_pkg::MAX_HEIGHT - 1);
			max_y_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
		end else if (take) begin
			if (smp.frame_end) begin
				area_q   <= '0;
				min_x_q  <= cfg.x_last;
				max_x_q  <= '0;
				min_y_q  <= cfg.y_last;
				max_y_q  <= '0;
				sum_x_q  <= '0;
				sum_y_q  <= '0;
				sum_xx_q <= '0;
				sum_yy_q <= '0;
				sum_xy_q <= '0;
			end else begin
				area_q   <= area_n;
				min_x_q  <= min_x_n;
				max_x_q  <= max_x_n;
				min_y_q  <= min_y_n;
				max_y_q  <= max_y_n;
				sum_x_q  <= sum_x_n;
				sum_y_q  <= sum_y_n;
				sum_xx_q <= sum_xx_n;
				sum_yy_q <= sum_yy_n;
				sum_xy_q <= sum_xy_n;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && smp.frame_end) begin
			out_valid_q <= 1'b1;
		end else if (moments.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; the minimums are capped at the last column and row.
	always_ff @(posedge clk) begin
		if (take && smp.frame_end) begin
			moments.area   <= area_n;
			moments.min_x  <= (min_x_n < cfg.x_last) ? min_x_n : cfg.x_last;
			moments.max_x  <= max_x_n;
			moments.min_y  <= (min_y_n < cfg.y_last) ? min_y_n : cfg.y_last;
			moments.max_y  <= max_y_n;
			moments.sum_x  <= sum_x_n;
			moments.sum_y  <= sum_y_n;
			moments.sum_xx <= sum_xx_n;
			moments.sum_yy <= sum_yy_n;
			moments.sum_xy <= sum_xy_n;
		end
	end

	assign moments.valid = out_valid_q;

endmodule

@@ src/color_blob_moment_stats.sv @@
// Raw image moments of one label inside a window, one result per frame.
// Pixels channel: one label byte per request, in raster order, one per clock unless stalled.
// Moments channel: one request per frame holding area, bounding box and the
// sums of x, y, x*x, y*y and x*y of the matching pixels.
// Configuration: write enable, register index and data; the user must write it
// only while no request is in flight; the block does not enforce this.
// Throughput: one pixel per clock unless a waiting result stalls the pipeline.
// The pixel path is three register stages: raster counters with the input
// register, the window test with the three 10x10 products, and the
// accumulators with the result register. The frame's last pixel passes stage
// one and stage two before the result register takes the result.
// Stall: while a result waits on the moments channel, pixels keep flowing; only
// the last pixel of the next frame is held, and the pixel pipeline backs up
// behind it until the waiting result is taken.
// Reset: registers return to a 1024 x 1024 frame, label one, full window; the
// raster position, area and sums clear, the box is empty, nothing in flight.
module color_blob_moment_stats (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [cbms_pkg::IDX_W-1:0]  cfg_idx,
	input  logic [cbms_pkg::SIZE_W-1:0] cfg_wdata,
	cbms_pixel_if.sink                  pixels,
	cbms_moment_if.source               moments
);

	cbms_pkg::cfg_t    cfg;
	logic              smp_valid;
	logic              smp_ready;
	cbms_pkg::sample_t smp;

	// Configuration registers.
	cbms_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Raster position, window test and products.
	cbms_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (pixels.valid),
		.in_label  (pixels.pixel_label),
		.in_ready  (pixels.ready),
		.smp_valid (smp_valid),
		.smp       (smp),
		.smp_ready (smp_ready)
	);

	// Accumulators and result register.
	cbms_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.smp_valid (smp_valid),
		.smp       (smp),
		.smp_ready (smp_ready),
		.moments   (moments)
	);

endmodule
